[hdl/msd_pkg.sv]
`default_nettype none

package msd_pkg;

    // symbol code values with a fixed meaning
    localparam logic [9:0] GAP_CODE     = 10'd104;
    localparam logic [9:0] CODE_MIN     = 10'd2;
    localparam logic [9:0] CODE_MAX     = 10'd257;
    localparam logic [9:0] BAD_CODE_A   = 10'd26;
    localparam logic [9:0] BAD_CODE_B   = 10'd52;
    localparam logic [9:0] BAD_CODE_C   = 10'd78;
    localparam logic [9:0] MARK_CODE_A  = 10'd25;
    localparam logic [9:0] MARK_CODE_B  = 10'd51;
    localparam logic [9:0] MARK_CODE_C  = 10'd77;
    localparam logic [9:0] MARK_CODE_D  = 10'd103;
    localparam logic [9:0] MARK_CODE_E  = 10'd129;

    // tree limits
    localparam int unsigned TREE_DEPTH  = 6;
    localparam int unsigned ROM_DEPTH   = 6;
    localparam int unsigned LETTERS     = 65;

    // result kinds
    localparam logic KIND_LETTER = 1'b0;
    localparam logic KIND_SPACE  = 1'b1;

    // decoder state record, one memory word
    typedef struct packed {
        logic       prev_gap;
        logic       prev_marker;
        logic       pprev_gap;
        logic [1:0] gap_count;
        logic [2:0] path_len;
        logic [5:0] path_bits;
    } state_t;

    // one result transaction
    typedef struct packed {
        logic       kind;
        logic [6:0] letter_index;
        logic       last;
    } result_t;

    // results produced by one symbol
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } emit_t;

endpackage

`default_nettype wire

[hdl/msd_step.sv]
`default_nettype none

module msd_step #(
    parameter int unsigned TREE_DEPTH = msd_pkg::TREE_DEPTH
) (
    input  wire logic [9:0]    code,
    input  wire msd_pkg::state_t cur,
    output msd_pkg::state_t    nxt,
    output msd_pkg::emit_t     emit
);
    import msd_pkg::*;

    localparam logic [6:0] NO_LABEL = 7'h7F;

    // tree rom: {length, symbols}, first symbol in the top used bit, 1 is dah
    localparam logic [8:0] TREE_ROM [0:LETTERS-1] = '{
        {3'd1, 6'd0},  {3'd2, 6'd0},  {3'd3, 6'd0},  {3'd4, 6'd0},  {3'd5, 6'd0},
        {3'd5, 6'd1},  {3'd4, 6'd1},  {3'd5, 6'd2},  {3'd5, 6'd3},  {3'd3, 6'd1},
        {3'd4, 6'd2},  {3'd5, 6'd4},  {3'd4, 6'd3},  {3'd5, 6'd6},  {3'd6, 6'd12},
        {3'd6, 6'd13}, {3'd5, 6'd7},  {3'd2, 6'd1},  {3'd3, 6'd2},  {3'd4, 6'd4},
        {3'd5, 6'd9},  {3'd6, 6'd18}, {3'd4, 6'd5},  {3'd5, 6'd10}, {3'd6, 6'd21},
        {3'd3, 6'd3},  {3'd4, 6'd6},  {3'd5, 6'd12}, {3'd5, 6'd13}, {3'd6, 6'd26},
        {3'd4, 6'd7},  {3'd5, 6'd14}, {3'd5, 6'd15}, {3'd1, 6'd1},  {3'd2, 6'd2},
        {3'd3, 6'd4},  {3'd4, 6'd8},  {3'd5, 6'd16}, {3'd6, 6'd33}, {3'd5, 6'd17},
        {3'd4, 6'd9},  {3'd5, 6'd18}, {3'd3, 6'd5},  {3'd4, 6'd10}, {3'd5, 6'd20},
        {3'd6, 6'd42}, {3'd6, 6'd43}, {3'd4, 6'd11}, {3'd5, 6'd22}, {3'd6, 6'd45},
        {3'd2, 6'd3},  {3'd3, 6'd6},  {3'd4, 6'd12}, {3'd5, 6'd24}, {3'd6, 6'd51},
        {3'd4, 6'd13}, {3'd5, 6'd26}, {3'd5, 6'd27}, {3'd3, 6'd7},  {3'd4, 6'd14},
        {3'd5, 6'd28}, {3'd6, 6'd56}, {3'd4, 6'd15}, {3'd5, 6'd30}, {3'd5, 6'd31}
    };

    // letter at a node, or none
    function automatic logic [6:0] node_label(input logic [2:0] len, input logic [5:0] bits);
        logic [6:0] lbl;
        lbl = NO_LABEL;
        for (int e = 0; e < LETTERS; e++)
        begin
            if (lbl == NO_LABEL && TREE_ROM[e][8:6] == len && TREE_ROM[e][5:0] == bits)
            begin
                lbl = 7'(e);
            end
        end
        return lbl;
    endfunction

    // a node exists when some letter code starts with its path
    function automatic logic node_exists(input logic [2:0] len, input logic [5:0] bits);
        logic       hit;
        logic [2:0] el;
        logic [5:0] eb;
        hit = 1'b0;
        for (int e = 0; e < LETTERS; e++)
        begin
            el = TREE_ROM[e][8:6];
            eb = TREE_ROM[e][5:0];
            if (el >= len && (eb >> (el - len)) == bits)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic even_in(input logic [9:0] c, input logic [9:0] lo,
                                     input logic [9:0] hi);
        return !c[0] && c >= lo && c <= hi;
    endfunction

    logic       code_ok;
    logic       is_gap;
    logic       is_marker;
    logic       set_dit;
    logic       set_dah;
    logic       any_dit;
    logic       any_dah;
    logic       do_root;
    logic       do_step;
    logic       step_sym;
    logic [1:0] gc_new;
    logic       emit_label;
    logic       emit_space;
    logic [6:0] label;
    logic [2:0] base_len;
    logic [5:0] base_bits;
    logic [3:0] step_len;
    logic [5:0] step_bits;
    logic       step_ok;
    result_t    letter_res;
    result_t    space_res;

    // code classification
    always_comb
    begin
        code_ok   = code >= CODE_MIN && code <= CODE_MAX && code != BAD_CODE_A
                    && code != BAD_CODE_B && code != BAD_CODE_C;
        is_gap    = code == GAP_CODE;
        is_marker = code == MARK_CODE_A || code == MARK_CODE_B || code == MARK_CODE_C
                    || code == MARK_CODE_D || code == MARK_CODE_E;
        set_dit   = even_in(code, 10'd2, 10'd8) || even_in(code, 10'd28, 10'd34);
        set_dah   = even_in(code, 10'd10, 10'd24) || even_in(code, 10'd36, 10'd50);
        any_dit   = even_in(code, 10'd54, 10'd60) || even_in(code, 10'd80, 10'd86)
                    || even_in(code, 10'd106, 10'd112);
        any_dah   = even_in(code, 10'd62, 10'd76) || even_in(code, 10'd88, 10'd102)
                    || even_in(code, 10'd114, 10'd128);
        label     = node_label(cur.path_len, cur.path_bits);
    end

    // gap, re-rooting and step decisions
    always_comb
    begin
        do_root    = 1'b0;
        do_step    = 1'b0;
        step_sym   = 1'b0;
        gc_new     = cur.gap_count;
        emit_label = 1'b0;
        emit_space = 1'b0;
        if (is_gap)
        begin
            if (cur.gap_count < 2'd2)
            begin
                emit_label = label != NO_LABEL;
                emit_space = cur.gap_count == 2'd1;
                do_root    = 1'b1;
                gc_new     = cur.gap_count + 2'd1;
            end
            if (cur.prev_marker)
            begin
                gc_new   = 2'd0;
                do_step  = 1'b1;
                step_sym = 1'b1;
            end
        end
        else if (cur.prev_gap && cur.pprev_gap)
        begin
            if (set_dit || set_dah)
            begin
                do_root  = cur.gap_count <= 2'd1;
                gc_new   = 2'd0;
                do_step  = 1'b1;
                step_sym = set_dah;
            end
        end
        else if (set_dit || set_dah)
        begin
            gc_new   = 2'd0;
            do_step  = 1'b1;
            step_sym = set_dah;
        end
        if (any_dit || any_dah)
        begin
            gc_new   = 2'd0;
            do_step  = 1'b1;
            step_sym = any_dah;
        end
    end

    // tree walk: one child step from the current node or the root
    always_comb
    begin
        base_len  = do_root ? 3'd0 : cur.path_len;
        base_bits = do_root ? 6'd0 : cur.path_bits;
        step_len  = {1'b0, base_len} + 4'd1;
        step_bits = {base_bits[4:0], step_sym};
        step_ok   = do_step && step_len <= 4'(TREE_DEPTH) && step_len <= 4'(ROM_DEPTH)
                    && node_exists(step_len[2:0], step_bits);
    end

    // next state record, invalid codes leave it untouched
    always_comb
    begin
        nxt = cur;
        if (code_ok)
        begin
            nxt.prev_gap    = is_gap;
            nxt.prev_marker = is_marker;
            nxt.pprev_gap   = cur.prev_gap;
            nxt.gap_count   = gc_new;
            nxt.path_len    = step_ok ? step_len[2:0] : base_len;
            nxt.path_bits   = step_ok ? step_bits : base_bits;
        end
    end

    // results for this symbol
    always_comb
    begin
        letter_res.kind         = KIND_LETTER;
        letter_res.letter_index = label;
        letter_res.last         = !emit_space;
        space_res.kind          = KIND_SPACE;
        space_res.letter_index  = 7'd0;
        space_res.last          = 1'b1;
        emit.count  = code_ok ? 2'({1'b0, emit_label} + {1'b0, emit_space}) : 2'd0;
        emit.first  = emit_label ? letter_res : space_res;
        emit.second = space_res;
    end

endmodule

`default_nettype wire

[hdl/msd_result_fifo.sv]
`default_nettype none

module msd_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msd_pkg::emit_t   push,
    output logic                  room,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output msd_pkg::result_t      head
);
    import msd_pkg::*;

    localparam int unsigned FIFO_DEPTH = 4;

    result_t    fifo_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    // room for the largest burst of one symbol
    assign room         = count_reg <= 3'(FIFO_DEPTH - 2);
    assign result_valid = count_reg != 3'd0;
    assign head         = fifo_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, up to two writes a cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

endmodule

`default_nettype wire

[hdl/morse_symbol_tree_decoder_unit.sv]
// a symbol waits in the stage register until it fires; its results then enter the fifo
// throughput: one symbol per cycle; state memory read, forwarded write and tree step form
// a read-modify-write loop; input stalls while three or more results wait in the
// four-entry result fifo, which drains one per cycle while result_ready is high
// reset: asynchronous, active low; clears pipeline and fifo control, and the state word
// reads as all zero (root, no history) until the first symbol writes it
`default_nettype none

module morse_symbol_tree_decoder_unit #(
    parameter int unsigned TREE_DEPTH = msd_pkg::TREE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       symbol_valid,
    output logic            symbol_ready,
    input  wire logic [9:0] symbol_code,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic            kind,
    output logic [6:0]      letter_index,
    output logic            last
);
    import msd_pkg::*;

    state_t     state_mem [1];
    state_t     rd_data_reg;
    state_t     wr_data_reg;
    state_t     st_cur;
    state_t     st_next;
    logic       s1_valid_reg;
    logic [9:0] s1_code_reg;
    logic       fwd_reg;
    logic       rd_seen_reg;
    logic       written_reg;
    logic       s1_fire;
    logic       symbol_fire;
    logic       room;
    emit_t      emit;
    emit_t      push;
    result_t    head;

    // handshakes
    assign s1_fire      = s1_valid_reg && room;
    assign symbol_ready = !s1_valid_reg || s1_fire;
    assign symbol_fire  = symbol_valid && symbol_ready;

    // state word: forward the write at the read edge, zero before the first write
    assign st_cur = fwd_reg ? wr_data_reg : (rd_seen_reg ? rd_data_reg : '0);

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            rd_seen_reg  <= 1'b0;
            written_reg  <= 1'b0;
        end
        else
        begin
            if (symbol_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire;
                rd_seen_reg  <= written_reg;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                written_reg <= 1'b1;
            end
        end
    end

    // symbol payload and forwarded write data
    always_ff @(posedge clk)
    begin
        if (symbol_fire)
        begin
            s1_code_reg <= symbol_code;
        end
        if (s1_fire)
        begin
            wr_data_reg <= st_next;
        end
    end

    // state memory, one word, read on each transaction
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            state_mem[0] <= st_next;
        end
        if (symbol_fire)
        begin
            rd_data_reg <= state_mem[0];
        end
    end

    msd_step #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_step (
        .code (s1_code_reg),
        .cur  (st_cur),
        .nxt  (st_next),
        .emit (emit)
    );

    // only a firing stage pushes results
    always_comb
    begin
        push       = emit;
        push.count = s1_fire ? emit.count : 2'd0;
    end

    msd_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign kind         = head.kind;
    assign letter_index = head.letter_index;
    assign last         = head.last;

endmodule

`default_nettype wire
